FILE: design/sobel_gradient_3x3_macros.svh
// assertion macros shared by the sobel gradient modules
`ifndef SOBEL_GRADIENT_3X3_MACROS_SVH
`define SOBEL_GRADIENT_3X3_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SG_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sobel_gradient_3x3 check failed");
// next-cycle implication
`define SG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sobel_gradient_3x3 check failed");
`else
`define SG_ASSERT_IMPL(lbl, ante, cons)
`define SG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/sg_pkg.sv
// shared types, constants and gradient helpers for the sobel gradient block
`timescale 1ns / 1ps
package sg_pkg;

	localparam int unsigned SG_SAMPLE_W = 16;
	localparam int unsigned SG_GRAD_W = 19;
	localparam int unsigned SG_CFG_W = 11;
	localparam int unsigned SG_IDX_W = 1;
	localparam int unsigned SG_FIFO_DEPTH = 8;
	localparam int unsigned SG_FIFO_AW = 3;
	localparam int unsigned SG_LVL_W = 5;
	localparam logic [SG_CFG_W-1:0] SG_WIDTH_RESET = 11'd1024;
	localparam logic [SG_CFG_W-1:0] SG_HEIGHT_RESET = 11'd1024;

	typedef enum logic {
		SG_CMD_PIXEL,
		SG_CMD_FLUSH
	} sg_cmd_t;

	typedef enum logic [SG_IDX_W-1:0] {
		SG_REG_WIDTH,
		SG_REG_HEIGHT
	} sg_reg_t;

	// one window column, top row first
	typedef struct packed {
		logic signed [SG_SAMPLE_W-1:0] top;
		logic signed [SG_SAMPLE_W-1:0] ctr;
		logic signed [SG_SAMPLE_W-1:0] bot;
	} sg_col_t;

	// per-request decisions taken at accept time
	typedef struct packed {
		logic is_flush;
		logic col_first;
		logic row_ge1;
		logic row_ge2;
		logic end_row;
		logic emit_a;
		logic emit_b;
		logic fl_first;
		logic fl_lz;
		logic fl_mz;
		logic fl_rz;
		logic fl_last;
	} sg_ctl_t;

	// assembled window; result b uses m, r and a zero column
	typedef struct packed {
		logic a_vld;
		logic b_vld;
		logic a_eor;
		logic a_eoi;
		sg_col_t l;
		sg_col_t m;
		sg_col_t r;
	} sg_win_t;

	typedef struct packed {
		logic signed [SG_GRAD_W-1:0] gx;
		logic signed [SG_GRAD_W-1:0] gy;
		logic eor;
		logic eoi;
	} sg_res_t;

	function automatic logic signed [SG_GRAD_W-1:0] sg_wsum(
		input logic signed [SG_SAMPLE_W-1:0] a,
		input logic signed [SG_SAMPLE_W-1:0] b,
		input logic signed [SG_SAMPLE_W-1:0] c
	);
		logic signed [SG_GRAD_W-1:0] ea;
		logic signed [SG_GRAD_W-1:0] eb;
		logic signed [SG_GRAD_W-1:0] ec;
		ea = SG_GRAD_W'(a);
		eb = SG_GRAD_W'(b);
		ec = SG_GRAD_W'(c);
		return ea + (eb <<< 1) + ec;
	endfunction

	function automatic sg_res_t sg_grad(
		input sg_col_t l,
		input sg_col_t m,
		input sg_col_t r,
		input logic eor,
		input logic eoi
	);
		sg_res_t res;
		res.gx = sg_wsum(l.top, l.ctr, l.bot) - sg_wsum(r.top, r.ctr, r.bot);
		res.gy = sg_wsum(l.top, m.top, r.top) - sg_wsum(l.bot, m.bot, r.bot);
		res.eor = eor;
		res.eoi = eoi;
		return res;
	endfunction

	// bottom-row flush column: two stored rows, zero below
	function automatic sg_col_t sg_fmask(
		input sg_col_t raw,
		input logic zero,
		input logic ge2
	);
		sg_col_t col;
		col = '0;
		if (!zero) begin
			col.top = ge2 ? raw.top : '0;
			col.ctr = raw.ctr;
		end
		return col;
	endfunction

endpackage

FILE: design/sg_if.sv
// stream and configuration interfaces of the sobel gradient block
`timescale 1ns / 1ps
interface sg_pix_if;
	import sg_pkg::*;
	logic valid;
	logic ready;
	sg_cmd_t cmd;
	logic signed [SG_SAMPLE_W-1:0] sample;
	modport source(output valid, cmd, sample, input ready);
	modport sink(input valid, cmd, sample, output ready);
endinterface

interface sg_res_if;
	import sg_pkg::*;
	logic valid;
	logic ready;
	logic signed [SG_GRAD_W-1:0] grad_x;
	logic signed [SG_GRAD_W-1:0] grad_y;
	logic end_of_run;
	logic end_of_image;
	modport source(output valid, grad_x, grad_y, end_of_run, end_of_image, input ready);
	modport sink(input valid, grad_x, grad_y, end_of_run, end_of_image, output ready);
endinterface

interface sg_cfg_if;
	import sg_pkg::*;
	logic valid;
	logic ready;
	logic [SG_IDX_W-1:0] index;
	logic [SG_CFG_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: design/sobel_gradient_3x3.sv
// sobel_gradient_3x3: streaming 3x3 sobel gradients over two line-store rams
// path: a request passes stage 1 and the gradient stage into the result queue, which offers its results
// throughput: one request per cycle; a row end yields two results, which the
// result queue drains at one per cycle, so ready drops while it is near full
// reset: counters clear, width and height return to 1024, line stores keep contents
`timescale 1ns / 1ps
module sobel_gradient_3x3 #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	sg_pix_if.sink  pix,
	sg_res_if.source res,
	sg_cfg_if.sink  cfg
);
	import sg_pkg::*;

	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// accept stage outputs
	logic                   go;
	logic [CW-1:0]          addr;
	sg_ctl_t                ctl;

	// stage 1: ram data back, window assembly and write-back
	logic                   v_s1;
	sg_ctl_t                ctl_s1;
	logic [CW-1:0]          addr_s1;
	logic signed [SG_SAMPLE_W-1:0] sample_s1;

	logic [SG_SAMPLE_W-1:0] old_rdata;
	logic [SG_SAMPLE_W-1:0] new_rdata;
	logic signed [SG_SAMPLE_W-1:0] o_rd;
	logic signed [SG_SAMPLE_W-1:0] n_rd;

	// forwarding of the last line-store write
	logic                   fw_vld_q;
	logic [CW-1:0]          fw_addr_q;
	logic signed [SG_SAMPLE_W-1:0] fw_old_q;
	logic signed [SG_SAMPLE_W-1:0] fw_new_q;
	logic                   fw_hit;

	// pixel window columns and flush window columns
	sg_col_t                win1_q;
	sg_col_t                win2_q;
	sg_col_t                col_a_q;
	sg_col_t                col_b_q;
	sg_col_t                hold0_q;
	sg_col_t                pix_col;
	sg_col_t                raw_r;
	sg_col_t                raw_m;
	sg_win_t                win;

	logic                   wr_en;
	logic [SG_LVL_W-1:0]    level;

	// accept decisions and frame counters
	sg_seq #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pix_valid(pix.valid),
		.pix_ready(pix.ready),
		.pix_cmd  (pix.cmd),
		.go       (go),
		.addr     (addr),
		.ctl      (ctl)
	);

	// room for two results per request in flight keeps the queue from overflowing
	assign pix.ready = (level + SG_LVL_W'({v_s1, 1'b0})) <= SG_LVL_W'(SG_FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ctl_s1    <= ctl;
			addr_s1   <= addr;
			sample_s1 <= pix.sample;
		end
	end

	// older row store holds row r-2, newer row store row r-1
	sg_ram #(
		.WIDTH(SG_SAMPLE_W),
		.DEPTH(MAX_WIDTH)
	) u_older (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(n_rd),
		.re   (go),
		.raddr(addr),
		.rdata(old_rdata)
	);

	sg_ram #(
		.WIDTH(SG_SAMPLE_W),
		.DEPTH(MAX_WIDTH)
	) u_newer (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(sample_s1),
		.re   (go),
		.raddr(addr),
		.rdata(new_rdata)
	);

	// a one-pixel row reads the entry written in the same cycle
	assign fw_hit = fw_vld_q && (fw_addr_q == addr_s1);
	assign o_rd   = fw_hit ? fw_old_q : old_rdata;
	assign n_rd   = fw_hit ? fw_new_q : new_rdata;
	assign wr_en  = v_s1 && !ctl_s1.is_flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_vld_q <= 1'b0;
		end else if (wr_en) begin
			fw_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fw_addr_q <= addr_s1;
			fw_old_q  <= n_rd;
			fw_new_q  <= sample_s1;
		end
	end

	always_comb begin
		// new column for a pixel, rows above the top read as zero
		pix_col.top = ctl_s1.row_ge2 ? o_rd : '0;
		pix_col.ctr = ctl_s1.row_ge1 ? n_rd : '0;
		pix_col.bot = sample_s1;

		// flush columns: raw store contents, masked per request
		raw_r.top = o_rd;
		raw_r.ctr = n_rd;
		raw_r.bot = '0;
		raw_m     = ctl_s1.fl_first ? hold0_q : col_b_q;

		if (ctl_s1.is_flush) begin
			win.l     = sg_fmask(col_a_q, ctl_s1.fl_lz, ctl_s1.row_ge2);
			win.m     = sg_fmask(raw_m, ctl_s1.fl_mz, ctl_s1.row_ge2);
			win.r     = sg_fmask(raw_r, ctl_s1.fl_rz, ctl_s1.row_ge2);
			win.a_vld = 1'b1;
			win.b_vld = 1'b0;
			win.a_eor = 1'b1;
			win.a_eoi = ctl_s1.fl_last;
		end else begin
			// left edge starts from zero columns
			win.l     = ctl_s1.col_first ? '0 : win1_q;
			win.m     = ctl_s1.col_first ? '0 : win2_q;
			win.r     = pix_col;
			win.a_vld = ctl_s1.emit_a;
			win.b_vld = ctl_s1.emit_b;
			win.a_eor = !ctl_s1.end_row;
			win.a_eoi = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			if (ctl_s1.is_flush) begin
				col_a_q <= raw_m;
				col_b_q <= raw_r;
			end else begin
				win1_q <= win.m;
				win2_q <= win.r;
				// column zero of the latest row feeds the first flush request
				if (ctl_s1.col_first) begin
					hold0_q.top <= n_rd;
					hold0_q.ctr <= sample_s1;
					hold0_q.bot <= '0;
				end
			end
		end
	end

	// gradients and result queue
	sg_grad_fifo u_grad (
		.clk    (clk),
		.arst_n (arst_n),
		.win_vld(v_s1),
		.win    (win),
		.res    (res),
		.level  (level)
	);

endmodule

FILE: design/sg_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module sg_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/sg_seq.sv
// request sequencer: configuration registers, frame counters, accept decisions
`timescale 1ns / 1ps
`include "sobel_gradient_3x3_macros.svh"
module sg_seq #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_HEIGHT = 1024,
	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	sg_cfg_if.sink          cfg,
	input  logic            pix_valid,
	input  logic            pix_ready,
	input  sg_pkg::sg_cmd_t pix_cmd,
	output logic            go,
	output logic [CW-1:0]   addr,
	output sg_pkg::sg_ctl_t ctl
);
	import sg_pkg::*;

	localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned KA = (CW + 1 > RW) ? CW + 1 : RW;
	localparam int unsigned KW = (KA > SG_CFG_W) ? KA + 1 : SG_CFG_W + 1;
	localparam int unsigned WCAP = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
	localparam int unsigned HCAP = (MAX_HEIGHT < 2047) ? MAX_HEIGHT : 2047;

	logic [SG_CFG_W-1:0] width_q;
	logic [SG_CFG_W-1:0] height_q;
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic [CW-1:0]       flush_q;

	logic [SG_CFG_W-1:0] eff_w;
	logic [SG_CFG_W-1:0] eff_h;
	logic [KW-1:0]       w_k;
	logic [KW-1:0]       c_k;
	logic [KW-1:0]       r_k;
	logic [KW-1:0]       f_k;
	logic                pixel_phase;
	logic                accept;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SG_WIDTH_RESET;
			height_q <= SG_HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (sg_reg_t'(cfg.index))
				SG_REG_WIDTH:  width_q <= cfg.data;
				SG_REG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_w = (width_q == '0) ? SG_CFG_W'(1) :
			((width_q > SG_CFG_W'(WCAP)) ? SG_CFG_W'(WCAP) : width_q);
		eff_h = (height_q == '0) ? SG_CFG_W'(1) :
			((height_q > SG_CFG_W'(HCAP)) ? SG_CFG_W'(HCAP) : height_q);
		w_k = KW'(eff_w);
		c_k = KW'(col_q);
		r_k = KW'(row_q);
		f_k = KW'(flush_q);
		pixel_phase = r_k < KW'(eff_h);
		accept = pix_valid && pix_ready;

		ctl.is_flush  = (pix_cmd == SG_CMD_FLUSH);
		ctl.col_first = (col_q == '0);
		ctl.row_ge1   = (row_q != '0);
		ctl.row_ge2   = (r_k >= KW'(2));
		ctl.end_row   = (c_k + KW'(1)) >= w_k;
		ctl.emit_a    = ctl.row_ge1 && !ctl.col_first;
		ctl.emit_b    = ctl.row_ge1 && ctl.end_row;
		ctl.fl_first  = (flush_q == '0);
		ctl.fl_lz     = ctl.fl_first || ((f_k - KW'(1)) >= w_k);
		ctl.fl_mz     = f_k >= w_k;
		ctl.fl_last   = (f_k + KW'(1)) >= w_k;
		ctl.fl_rz     = ctl.fl_last;

		go   = accept && (ctl.is_flush ? !pixel_phase : pixel_phase);
		addr = ctl.is_flush ? (flush_q + CW'(1)) : col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= '0;
		end else if (go) begin
			if (ctl.is_flush) begin
				if (ctl.fl_last) begin
					col_q   <= '0;
					row_q   <= '0;
					flush_q <= '0;
				end else begin
					flush_q <= flush_q + CW'(1);
				end
			end else if (ctl.end_row) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	`SG_ASSERT_NEXT(a_frame_restart, go && ctl.is_flush && ctl.fl_last, row_q == '0 && col_q == '0 && flush_q == '0)
	`SG_ASSERT_NEXT(a_row_wrap, go && !ctl.is_flush && ctl.end_row, col_q == '0)

endmodule

FILE: design/sg_grad_fifo.sv
// gradient stage and result queue
`timescale 1ns / 1ps
`include "sobel_gradient_3x3_macros.svh"
module sg_grad_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         win_vld,
	input  sg_pkg::sg_win_t              win,
	sg_res_if.source                     res,
	output logic [sg_pkg::SG_LVL_W-1:0]  level
);
	import sg_pkg::*;

	logic                  v_s2;
	sg_win_t               win_s2;
	sg_res_t               res_a;
	sg_res_t               res_b;
	sg_res_t               first;
	logic [1:0]            push_n;
	logic                  pop;
	sg_res_t               fifo_q [SG_FIFO_DEPTH];
	logic [SG_FIFO_AW-1:0] wp_q;
	logic [SG_FIFO_AW-1:0] rp_q;
	logic [SG_LVL_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= win_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (win_vld) begin
			win_s2 <= win;
		end
	end

	always_comb begin
		res_a  = sg_grad(win_s2.l, win_s2.m, win_s2.r, win_s2.a_eor, win_s2.a_eoi);
		res_b  = sg_grad(win_s2.m, win_s2.r, '0, 1'b1, 1'b0);
		first  = win_s2.a_vld ? res_a : res_b;
		push_n = v_s2 ? (2'(win_s2.a_vld) + 2'(win_s2.b_vld)) : 2'd0;
		pop    = res.valid && res.ready;
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wp_q] <= first;
		end
		if (push_n == 2'd2) begin
			fifo_q[wp_q + SG_FIFO_AW'(1)] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + SG_FIFO_AW'(push_n);
			rp_q  <= rp_q + SG_FIFO_AW'(pop);
			cnt_q <= cnt_q + SG_LVL_W'(push_n) - SG_LVL_W'(pop);
		end
	end

	assign res.valid        = (cnt_q != '0);
	assign res.grad_x       = fifo_q[rp_q].gx;
	assign res.grad_y       = fifo_q[rp_q].gy;
	assign res.end_of_run   = fifo_q[rp_q].eor;
	assign res.end_of_image = fifo_q[rp_q].eoi;

	// queued results plus room for two while a window is in the gradient stage
	assign level = cnt_q + (v_s2 ? SG_LVL_W'(2) : SG_LVL_W'(0));

	`SG_ASSERT_IMPL(a_no_overflow, v_s2, (cnt_q + SG_LVL_W'(push_n)) <= (SG_LVL_W'(SG_FIFO_DEPTH) + SG_LVL_W'(pop)))
	`SG_ASSERT_IMPL(a_level_bound, 1'b1, level <= SG_LVL_W'(SG_FIFO_DEPTH))

endmodule

FILE: verif/sobel_gradient_3x3_tb.sv
// self-checking testbench for the streaming 3x3 sobel gradient block
`timescale 1ns / 1ps
module sobel_gradient_3x3_tb;
	import sg_pkg::*;

	localparam int unsigned MAX_W = 1024;
	localparam int unsigned MAX_H = 1024;
	// margin for the block's stage 1, gradient stage and result queue; settle margin on top
	localparam int unsigned DRAIN_CYCLES = 12;
	// long receiver hold-off that backs the block up into its input
	localparam int unsigned HOLD_CYCLES = 300;
	localparam longint unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned RANDOM_ITEMS = 750;
	localparam logic signed [SG_SAMPLE_W-1:0] S_MAX = 16'sh7fff;
	localparam logic signed [SG_SAMPLE_W-1:0] S_MIN = 16'sh8000;

	// one request on the pixel stream
	typedef struct {
		sg_cmd_t cmd;
		logic signed [SG_SAMPLE_W-1:0] sample;
	} pix_req_t;

	logic clk = 1'b0;
	logic arst_n;

	sg_pix_if pix_ch();
	sg_res_if res_ch();
	sg_cfg_if cfg_ch();

	sobel_gradient_3x3 #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// gradient predictor: own copy of registers, line stores and window
	// ---------------------------------------------------------------
	logic [SG_CFG_W-1:0] width_reg;
	logic [SG_CFG_W-1:0] height_reg;
	logic signed [SG_SAMPLE_W-1:0] older_line [MAX_W];
	logic signed [SG_SAMPLE_W-1:0] newer_line [MAX_W];
	sg_col_t win_left;
	sg_col_t win_mid;
	sg_col_t win_right;
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned flush_pos;
	sg_res_t pending_gradients [$];

	// out-of-range register values clamp: zero acts as one, above max as max
	function automatic int unsigned active_width();
		if (width_reg == '0) return 1;
		if (width_reg > MAX_W) return MAX_W;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned active_height();
		if (height_reg == '0) return 1;
		if (height_reg > MAX_H) return MAX_H;
		return 32'(height_reg);
	endfunction

	// 1-2-1 weighted sum, full precision
	function automatic int weigh121(int a, int b, int c);
		return a + 2 * b + c;
	endfunction

	task automatic push_gradient(sg_col_t l, sg_col_t m, sg_col_t r, logic eor, logic eoi);
		int gx;
		int gy;
		sg_res_t g;
		// columns hold top (two rows up), center (one row up), bottom (newest)
		gx = weigh121(l.top, l.ctr, l.bot) - weigh121(r.top, r.ctr, r.bot);
		gy = weigh121(l.top, m.top, r.top) - weigh121(l.bot, m.bot, r.bot);
		g.gx = gx[SG_GRAD_W-1:0];
		g.gy = gy[SG_GRAD_W-1:0];
		g.eor = eor;
		g.eoi = eoi;
		pending_gradients.push_back(g);
	endtask

	task automatic gradients_for_pixel(logic signed [SG_SAMPLE_W-1:0] s);
		int unsigned w;
		int unsigned c;
		int unsigned r;
		logic end_row;
		sg_col_t col;
		w = active_width();
		c = col_pos;
		r = row_pos;
		// a counter at or past the last column ends the row here
		end_row = (c + 1 >= w);
		col.top = (r >= 2) ? older_line[c] : '0;
		col.ctr = (r >= 1) ? newer_line[c] : '0;
		col.bot = s;
		// left image edge: columns outside count as zero
		if (c == 0) begin
			win_left = '0;
			win_mid = '0;
		end else begin
			win_left = win_mid;
			win_mid = win_right;
		end
		win_right = col;
		older_line[c] = newer_line[c];
		newer_line[c] = s;
		// top row gives nothing; otherwise one pixel up-left, plus right edge at row end
		if (r >= 1) begin
			if (c >= 1) push_gradient(win_left, win_mid, win_right, !end_row, 1'b0);
			if (end_row) push_gradient(win_mid, win_right, '0, 1'b1, 1'b0);
		end
		if (end_row) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	// bottom-row column: the two stored rows, zero below and off the edges
	function automatic sg_col_t bottom_column(int idx, int unsigned w);
		sg_col_t col;
		col = '0;
		if (idx >= 0 && idx < int'(w)) begin
			if (row_pos >= 2) col.top = older_line[idx];
			col.ctr = newer_line[idx];
		end
		return col;
	endfunction

	task automatic gradients_for_flush();
		int unsigned w;
		int unsigned f;
		logic last;
		w = active_width();
		f = flush_pos;
		last = (f + 1 >= w);
		push_gradient(bottom_column(int'(f) - 1, w), bottom_column(int'(f), w),
			bottom_column(int'(f) + 1, w), 1'b1, last);
		// last flush of the frame restarts every counter
		if (last) begin
			col_pos = 0;
			row_pos = 0;
			flush_pos = 0;
			win_left = '0;
			win_mid = '0;
			win_right = '0;
		end else begin
			flush_pos = f + 1;
		end
	endtask

	// flush in pixel phase and pixel in flush phase are dropped by the block
	task automatic compute_gradients(pix_req_t q);
		logic pixel_phase;
		pixel_phase = (row_pos < active_height());
		if (q.cmd == SG_CMD_FLUSH) begin
			if (!pixel_phase) gradients_for_flush();
		end else begin
			if (pixel_phase) gradients_for_pixel(q.sample);
		end
	endtask

	// ---------------------------------------------------------------
	// idling control and counters
	// ---------------------------------------------------------------
	pix_req_t stream_requests [$];
	pix_req_t req_on_bus;
	int unsigned requests_queued = 0;
	int unsigned requests_taken = 0;
	int unsigned src_gap_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned src_gap_left = 0;
	int unsigned sink_stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned hold_asked = 0;
	int unsigned hold_served = 0;
	int unsigned fail_count = 0;
	int unsigned grads_checked = 0;
	int unsigned ignored_count = 0;
	int unsigned frames_sent = 0;
	int unsigned random_items = 0;
	longint unsigned cycle_count = 0;
	sg_res_t grad_want;

	// mostly short gaps, a few long ones
	function automatic int unsigned idle_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic int unsigned pick_idle_pct();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return 0;
		if (roll < 80) return 15;
		return 40;
	endfunction

	// ---------------------------------------------------------------
	// pixel stream driver: predicts each request as it is taken
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				compute_gradients(req_on_bus);
				requests_taken++;
			end
			// valid only changes once the current request is gone
			if (!pix_ch.valid || pix_ch.ready) begin
				if (src_gap_left != 0) begin
					src_gap_left--;
					pix_ch.valid <= 1'b0;
				end else if (stream_requests.size() != 0 && $urandom_range(0, 99) < src_gap_pct) begin
					src_gap_left = idle_length() - 1;
					pix_ch.valid <= 1'b0;
				end else if (stream_requests.size() != 0) begin
					req_on_bus = stream_requests.pop_front();
					pix_ch.valid <= 1'b1;
					pix_ch.cmd <= req_on_bus.cmd;
					pix_ch.sample <= req_on_bus.sample;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor: checks against the oldest expected gradient
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_gradients.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual gx %0d gy %0d eor %0b eoi %0b",
						$time, res_ch.grad_x, res_ch.grad_y, res_ch.end_of_run, res_ch.end_of_image);
					fail_count++;
				end else begin
					grad_want = pending_gradients.pop_front();
					if (res_ch.grad_x !== grad_want.gx || res_ch.grad_y !== grad_want.gy ||
						res_ch.end_of_run !== grad_want.eor || res_ch.end_of_image !== grad_want.eoi) begin
						$display("%0t: mismatch, expected gx %0d gy %0d eor %0b eoi %0b", $time,
							grad_want.gx, grad_want.gy, grad_want.eor, grad_want.eoi);
						$display("%0t:           actual gx %0d gy %0d eor %0b eoi %0b", $time,
							res_ch.grad_x, res_ch.grad_y, res_ch.end_of_run, res_ch.end_of_image);
						fail_count++;
					end
					grads_checked++;
				end
			end
			// long hold-off first, then random stalls
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_served != hold_asked) begin
				hold_served++;
				hold_left = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else if (sink_stall_left != 0) begin
				sink_stall_left--;
				res_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < sink_stall_pct) begin
				sink_stall_left = idle_length() - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic push_req(sg_cmd_t cmd, logic signed [SG_SAMPLE_W-1:0] s);
		pix_req_t q;
		q.cmd = cmd;
		q.sample = s;
		stream_requests.push_back(q);
		requests_queued++;
	endtask

	function automatic logic signed [SG_SAMPLE_W-1:0] pick_sample();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 6) return S_MAX;
		if (roll < 12) return S_MIN;
		if (roll < 20) return 16'($urandom_range(0, 15) - 8);
		return 16'($urandom());
	endfunction

	// block idle: all requests taken, all gradients back, pipeline settled
	task automatic wait_idle();
		@(posedge clk);
		while (requests_taken != requests_queued || pending_gradients.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(sg_reg_t idx, logic [SG_CFG_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == SG_REG_WIDTH) width_reg = value;
		else height_reg = value;
	endtask

	// image size changes only at a frame boundary with the block idle
	task automatic set_dims(logic [SG_CFG_W-1:0] wraw, logic [SG_CFG_W-1:0] hraw);
		if (wraw != width_reg || hraw != height_reg) wait_idle();
		if (wraw != width_reg) write_reg(SG_REG_WIDTH, wraw);
		if (hraw != height_reg) write_reg(SG_REG_HEIGHT, hraw);
	endtask

	// full frame of random pixels then its flush requests; noise is dropped by the block
	task automatic send_frame(int unsigned w, int unsigned h, int unsigned noise_pct);
		for (int unsigned i = 0; i < w * h; i++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				push_req(SG_CMD_FLUSH, 16'($urandom()));
				ignored_count++;
			end
			push_req(SG_CMD_PIXEL, pick_sample());
		end
		for (int unsigned i = 0; i < w; i++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				push_req(SG_CMD_PIXEL, pick_sample());
				ignored_count++;
			end
			push_req(SG_CMD_FLUSH, 16'($urandom()));
		end
		frames_sent++;
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned roll;
		int unsigned fw;
		int unsigned fh;
		int unsigned reps;
		int unsigned noise;
		logic [SG_CFG_W-1:0] wraw;
		logic [SG_CFG_W-1:0] hraw;

		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.cmd = SG_CMD_PIXEL;
		pix_ch.sample = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = SG_REG_WIDTH;
		cfg_ch.data = '0;
		width_reg = SG_WIDTH_RESET;
		height_reg = SG_HEIGHT_RESET;
		for (int i = 0; i < MAX_W; i++) begin
			older_line[i] = '0;
			newer_line[i] = '0;
		end
		win_left = '0;
		win_mid = '0;
		win_right = '0;
		col_pos = 0;
		row_pos = 0;
		flush_pos = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: 3x3 frame with full-scale columns, max horizontal gradient at center
		src_gap_pct <= 20;
		sink_stall_pct <= 20;
		set_dims(3, 3);
		push_req(SG_CMD_FLUSH, S_MIN);           // flush while pixels expected: dropped
		ignored_count++;
		push_req(SG_CMD_PIXEL, S_MAX);
		push_req(SG_CMD_PIXEL, 16'sd5);
		push_req(SG_CMD_PIXEL, S_MIN);
		push_req(SG_CMD_PIXEL, S_MAX);
		push_req(SG_CMD_PIXEL, 16'sd0);
		push_req(SG_CMD_PIXEL, S_MIN);
		push_req(SG_CMD_PIXEL, S_MAX);
		push_req(SG_CMD_PIXEL, -16'sd1);
		push_req(SG_CMD_PIXEL, S_MIN);
		push_req(SG_CMD_FLUSH, S_MAX);
		push_req(SG_CMD_PIXEL, S_MAX);           // pixel during bottom-row flush: dropped
		ignored_count++;
		push_req(SG_CMD_FLUSH, 16'sd0);
		push_req(SG_CMD_FLUSH, -16'sd1);
		frames_sent++;

		// smallest image: one pixel, one flush
		set_dims(1, 1);
		push_req(SG_CMD_PIXEL, S_MIN);
		push_req(SG_CMD_FLUSH, 16'sd0);
		frames_sent++;

		// shrink width then height in the middle of a 4x4 frame
		set_dims(4, 4);
		push_req(SG_CMD_PIXEL, S_MAX);
		push_req(SG_CMD_PIXEL, S_MIN);
		push_req(SG_CMD_PIXEL, 16'sd77);
		push_req(SG_CMD_PIXEL, -16'sd300);
		push_req(SG_CMD_PIXEL, S_MIN);
		push_req(SG_CMD_PIXEL, S_MAX);
		wait_idle();
		write_reg(SG_REG_WIDTH, 2);              // column already past the new last one
		push_req(SG_CMD_PIXEL, 16'sd1234);
		wait_idle();
		write_reg(SG_REG_HEIGHT, 2);             // row count reaches the new height: flush phase
		push_req(SG_CMD_FLUSH, 16'sd0);
		push_req(SG_CMD_FLUSH, 16'sd0);
		frames_sent++;

		// wide frame, no idling on the sender; one long receiver hold backs the block up
		src_gap_pct <= 0;
		sink_stall_pct <= 0;
		set_dims(64, 3);
		send_frame(64, 3, 0);
		hold_asked <= hold_asked + 1;

		// tall one-pixel-wide frame, zero width acts as one
		src_gap_pct <= 25;
		sink_stall_pct <= 25;
		set_dims(0, 48);
		send_frame(1, 48, 0);

		// random frames, mostly small, sizes kept for a few frames back to back
		while (random_items < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				fw = $urandom_range(1, 8);
				fh = $urandom_range(1, 6);
			end else if (roll < 95) begin
				fw = $urandom_range(9, 40);
				fh = $urandom_range(1, 8);
			end else begin
				fw = $urandom_range(41, 100);
				fh = $urandom_range(1, 2);
			end
			wraw = SG_CFG_W'(fw);
			hraw = SG_CFG_W'(fh);
			if (fw == 1 && $urandom_range(0, 4) == 0) wraw = 0;
			if (fh == 1 && $urandom_range(0, 4) == 0) hraw = 0;
			set_dims(wraw, hraw);
			src_gap_pct <= pick_idle_pct();
			sink_stall_pct <= pick_idle_pct();
			reps = $urandom_range(1, 3);
			noise = ($urandom_range(0, 9) == 0) ? 8 : 0;
			repeat (reps) begin
				if (random_items < RANDOM_ITEMS) begin
					send_frame(fw, fh, noise);
					random_items += fw * fh + fw;
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d frames from 1x1 up to 100 wide and 48 tall, zero-size registers,",
			frames_sent);
		$display("mid-frame resizing and a long receiver hold; %0d requests taken (%0d dropped), %0d gradients checked",
			requests_taken, ignored_count, grads_checked);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
